FILE: sv/unsigned_restoring_divider_core_assert.svh
`ifndef UNSIGNED_RESTORING_DIVIDER_CORE_ASSERT_SVH
`define UNSIGNED_RESTORING_DIVIDER_CORE_ASSERT_SVH

// check cons on the cycle after ante
`define URD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("divider check failed");

// check cons on the same cycle as ante
`define URD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("divider check failed");

`endif

FILE: sv/urd_pkg.sv
package urd_pkg;

	localparam int URD_WIDTH   = 32;
	localparam int URD_FIELD_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} urd_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} urd_ctl_t;

endpackage

FILE: sv/urd_req_if.sv
interface urd_req_if;
	logic                          valid;
	logic                          ready;
	logic [urd_pkg::URD_FIELD_W-1:0] dividend;
	logic [urd_pkg::URD_FIELD_W-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink (input valid, input dividend, input divisor, output ready);
endinterface

FILE: sv/urd_rsp_if.sv
interface urd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [urd_pkg::URD_FIELD_W-1:0] quotient;
	logic [urd_pkg::URD_FIELD_W-1:0] remainder;
	logic                          divide_by_zero;

	modport source (output valid, output quotient, output remainder, output divide_by_zero,
		input ready);
	modport sink (input valid, input quotient, input remainder, input divide_by_zero,
		output ready);
endinterface

FILE: sv/urd_cell.sv
module urd_cell (
	input  logic            clk,
	input  urd_pkg::urd_ctl_t ctl,
	input  logic            num_bit,
	input  logic            den_bit,
	input  logic            shift_in,
	input  logic            qd_in,
	input  logic            borrow_in,
	input  logic            take,
	output logic            rem_bit,
	output logic            qd_bit,
	output logic            borrow_out
);
	logic rem_q;
	logic qd_q;
	logic den_q;
	logic diff_bit;

	// one bit of (shifted remainder - divisor), ripple borrow
	assign diff_bit   = shift_in ^ den_q ^ borrow_in;
	assign borrow_out = (~shift_in & den_q) | (~(shift_in ^ den_q) & borrow_in);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= 1'b0;
			qd_q  <= num_bit;
			den_q <= den_bit;
		end else if (ctl.step) begin
			rem_q <= take ? diff_bit : shift_in;
			qd_q  <= qd_in;
		end
	end

	assign rem_bit = rem_q;
	assign qd_bit  = qd_q;
endmodule

FILE: sv/urd_row.sv
module urd_row #(
	parameter int WIDTH = urd_pkg::URD_WIDTH
) (
	input  logic              clk,
	input  urd_pkg::urd_ctl_t ctl,
	input  logic [WIDTH-1:0]  num,
	input  logic [WIDTH-1:0]  den,
	output logic [WIDTH-1:0]  rem,
	output logic [WIDTH-1:0]  quo
);
	logic [WIDTH-1:0] qd;
	logic [WIDTH-1:0] borrow;
	logic [WIDTH-1:0] shift_vec;
	logic [WIDTH-1:0] qd_in_vec;
	logic [WIDTH-1:0] borrow_in_vec;
	logic             take;

	// dividend bits leave the top of qd into the remainder, quotient bits enter at bit 0
	assign shift_vec     = {rem[WIDTH-2:0], qd[WIDTH-1]};
	assign qd_in_vec     = {qd[WIDTH-2:0], take};
	assign borrow_in_vec = {borrow[WIDTH-2:0], 1'b0};

	// bit shifted out of the remainder top makes the widened value exceed any divisor
	assign take = rem[WIDTH-1] | ~borrow[WIDTH-1];

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		urd_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.num_bit    (num[i]),
			.den_bit    (den[i]),
			.shift_in   (shift_vec[i]),
			.qd_in      (qd_in_vec[i]),
			.borrow_in  (borrow_in_vec[i]),
			.take       (take),
			.rem_bit    (rem[i]),
			.qd_bit     (qd[i]),
			.borrow_out (borrow[i])
		);
	end

	assign quo = qd;
endmodule

FILE: sv/unsigned_restoring_divider_core.sv
// Unsigned restoring divider. A dividend/divisor beat is taken when the core is idle and
// loaded into a row of WIDTH bit cells. The row then produces one quotient bit per cycle
// with a ripple-borrow subtract across the cells, and once the output register is free
// quotient and remainder are moved into it. The single row of cells is reused for every
// quotient bit. The next beat is accepted as soon as the result is in the output
// register, while that result still waits to be taken, so the core takes no new beat
// before it is through with the last one. Operands are cut to the low WIDTH bits;
// results are sized to 32 bits. A zero divisor returns quotient 0, remainder 0 and
// divide_by_zero set.
module unsigned_restoring_divider_core #(
	parameter int WIDTH = urd_pkg::URD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	urd_req_if.sink   req,
	urd_rsp_if.source rsp
);
	import urd_pkg::*;

	localparam int CNT_W = $clog2(WIDTH + 1);

	urd_state_t             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   dbz_q;
	logic                   rsp_valid_q;
	logic [URD_FIELD_W-1:0] quo_q;
	logic [URD_FIELD_W-1:0] rem_q;
	logic                   dbz_out_q;

	urd_ctl_t         ctl;
	logic [WIDTH-1:0] num;
	logic [WIDTH-1:0] den;
	logic [WIDTH-1:0] row_rem;
	logic [WIDTH-1:0] row_quo;
	logic             steps_done;
	logic             finish;

	assign num = WIDTH'(req.dividend);
	assign den = WIDTH'(req.divisor);

	assign steps_done = (cnt_q == CNT_W'(WIDTH));
	assign ctl.load   = (state_q == ST_IDLE) && req.valid;
	assign ctl.step   = (state_q == ST_RUN) && !steps_done;
	assign finish     = (state_q == ST_RUN) && steps_done && (!rsp_valid_q || rsp.ready);

	assign req.ready = (state_q == ST_IDLE);

	urd_row #(.WIDTH(WIDTH)) u_row (
		.clk (clk),
		.ctl (ctl),
		.num (num),
		.den (den),
		.rem (row_rem),
		.quo (row_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (!steps_done) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dbz_q <= (den == '0);
		end
		if (finish) begin
			quo_q     <= dbz_q ? '0 : URD_FIELD_W'(row_quo);
			rem_q     <= dbz_q ? '0 : URD_FIELD_W'(row_rem);
			dbz_out_q <= dbz_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.quotient       = quo_q;
	assign rsp.remainder      = rem_q;
	assign rsp.divide_by_zero = dbz_out_q;
endmodule

FILE: sv/urd_checker.sv
`include "unsigned_restoring_divider_core_assert.svh"

module urd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] quotient,
	input logic [31:0] remainder,
	input logic        divide_by_zero
);
	// a pending beat is held until taken
	`URD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	// an accepted beat keeps the core busy on the next cycle
	`URD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	// a new result frees the input side on the same edge
	`URD_ASSERT_SAME(a_ready_at_result, clk, arst_n, $rose(rsp_valid), req_ready)
	// zero divisor gives zero results
	`URD_ASSERT_SAME(a_dbz_zero, clk, arst_n, rsp_valid && divide_by_zero,
		quotient == 32'd0 && remainder == 32'd0)
endmodule

bind unsigned_restoring_divider_core urd_checker u_urd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.quotient       (rsp.quotient),
	.remainder      (rsp.remainder),
	.divide_by_zero (rsp.divide_by_zero)
);

FILE: verif/unsigned_restoring_divider_core_tb.sv
`timescale 1ns / 1ps

module unsigned_restoring_divider_core_tb;

	localparam int MAX_GAP    = 18;
	localparam int N_RANDOM   = 1430;
	localparam int HOLD_LEN   = 400;
	localparam int HOLD_AT    = 300;
	localparam int DRAIN_CYC  = 40;
	localparam int CYCLE_CAP  = 600000;
	localparam int NUM_DIR    = 20;

	typedef struct packed {
		logic [31:0] quotient;
		logic [31:0] remainder;
		logic        dbz;
	} div_res_t;

	typedef struct packed {
		logic [31:0] dividend;
		logic [31:0] divisor;
		logic        known;
		div_res_t    res;
	} div_vec_t;

	// known = 1: expected result typed in; otherwise taken from the predictor
	localparam div_vec_t DIR_TBL [NUM_DIR] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b1}},
		'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b1}},
		'{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
		'{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
		'{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0001, 1'b0}},
		'{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
		'{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0}},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0}},
		'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFE, 1'b0}},
		'{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0}},
		'{32'hDEAD_BEEF, 32'h8000_0001, 1'b1, '{32'h0000_0001, 32'h5EAD_BEEE, 1'b0}},
		'{32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
		'{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0000_0002, 32'h0000_0000, 1'b0}},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, 32'h5555_5555, 1'b0}},
		'{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 32'h0000_0000, 1'b0}},
		'{32'h0000_0064, 32'h0000_0007, 1'b0, '0},
		'{32'h1234_5678, 32'h0000_1234, 1'b0, '0},
		'{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	urd_req_if req_ch ();
	urd_rsp_if rsp_ch ();

	unsigned_restoring_divider_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	div_res_t quot_rem_q [$];
	int       errors    = 0;
	int       n_sent    = 0;
	int       n_checked = 0;
	int       n_zero    = 0;
	int       n_topden  = 0;
	int       cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout, %0d results still expected", $time, quot_rem_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic div_res_t udiv_restoring(logic [31:0] num, logic [31:0] den);
		div_res_t    res;
		logic [31:0] q;
		logic [31:0] r;
		logic [32:0] wide;
		logic        take;
		res = '0;
		q = '0;
		r = '0;
		if (den == 32'd0) begin
			res.dbz = 1'b1;
		end else if (den > num) begin
			res.remainder = num;
		end else if (den == num) begin
			res.quotient = 32'd1;
		end else begin
			for (int i = 31; i >= 0; i--) begin
				wide = {r, num[i]};
				take = (wide >= {1'b0, den});
				if (take)
					wide = wide - {1'b0, den};
				r = wide[31:0];
				q = {q[30:0], take};
			end
			res.quotient  = q;
			res.remainder = r;
		end
		return res;
	endfunction

	task automatic send_div(logic [31:0] num, logic [31:0] den, div_res_t exp_res);
		int gap;
		gap = ((n_sent / 50) % 4 == 2) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.dividend <= num;
		req_ch.divisor  <= den;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		quot_rem_q.push_back(exp_res);
		n_sent++;
		if (den == 32'd0)
			n_zero++;
		if (den[31])
			n_topden++;
	endtask

	initial begin
		logic [31:0] num;
		logic [31:0] den;
		int          pick;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.dividend = '0;
		req_ch.divisor  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			send_div(DIR_TBL[i].dividend, DIR_TBL[i].divisor,
				DIR_TBL[i].known ? DIR_TBL[i].res :
				udiv_restoring(DIR_TBL[i].dividend, DIR_TBL[i].divisor));
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			num  = $urandom;
			den  = $urandom;
			if (pick < 40) begin
			end else if (pick < 55) begin
				den = $urandom_range(1, 255);
			end else if (pick < 62) begin
				den = '0;
			end else if (pick < 70) begin
				num = num >> $urandom_range(1, 31);
				den = den | 32'h8000_0000;
			end else if (pick < 76) begin
				den = num;
			end else if (pick < 86) begin
				den = den | 32'h8000_0000;
			end else begin
				den = den >> $urandom_range(0, 31);
			end
			send_div(num, den, udiv_restoring(num, den));
		end
		req_ch.valid <= 1'b0;

		while (quot_rem_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (quot_rem_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, quot_rem_q.size());
			errors++;
		end

		$display("%0d divisions sent, %0d results checked", n_sent, n_checked);
		$display("%0d with zero divisor, %0d with divisor at or above 2^31", n_zero, n_topden);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int       stall;
		bit       held;
		div_res_t exp_res;
		held         = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_checked == HOLD_AT) begin
				stall = HOLD_LEN;
				held  = 1'b1;
			end else if ((n_checked / 40) % 4 == 1) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			if (quot_rem_q.size() == 0) begin
				$display("%0t: unexpected beat q=%h r=%h dbz=%b", $time,
					rsp_ch.quotient, rsp_ch.remainder, rsp_ch.divide_by_zero);
				errors++;
			end else begin
				exp_res = quot_rem_q.pop_front();
				n_checked++;
				if (rsp_ch.quotient !== exp_res.quotient) begin
					$display("%0t: quotient expected %h actual %h", $time,
						exp_res.quotient, rsp_ch.quotient);
					errors++;
				end
				if (rsp_ch.remainder !== exp_res.remainder) begin
					$display("%0t: remainder expected %h actual %h", $time,
						exp_res.remainder, rsp_ch.remainder);
					errors++;
				end
				if (rsp_ch.divide_by_zero !== exp_res.dbz) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						exp_res.dbz, rsp_ch.divide_by_zero);
					errors++;
				end
			end
		end
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/urd_pkg.sv
sv/urd_req_if.sv
sv/urd_rsp_if.sv
sv/urd_cell.sv
sv/urd_row.sv
sv/unsigned_restoring_divider_core.sv
sv/urd_checker.sv
verif/unsigned_restoring_divider_core_tb.sv
